// ----- design/cest_pkg.sv -----
// Shared types for the calibrated elapsed-time and sleep timer.
// Request and result payloads plus the accumulator-to-divider handoff.
// No dependencies.
`default_nettype none

package cest_pkg;

  // widths fixed by the payload fields
  localparam int US_W    = 64;
  localparam int SEC_W   = 45;
  localparam int REM_W   = 20;
  localparam int KIND_W  = 3;
  localparam int TICKS_W = 48;
  localparam int CAL_W   = 32;

  // request kinds; the codes above the query are unused and act as a query
  localparam logic [KIND_W-1:0] KIND_SAMPLE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SHUTDOWN = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BOOT     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUERY    = 3'd4;

  // one request
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [TICKS_W-1:0] tick_count;
    logic [CAL_W-1:0]   period_cal;
    logic               woke_from_sleep;
  } item_t;

  // one result
  typedef struct packed {
    logic [US_W-1:0]  elapsed_us;
    logic [SEC_W-1:0] elapsed_seconds;
    logic [SEC_W-1:0] inactivity_seconds;
  } result_t;

  // request after the microsecond total has been updated
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              woke;
    logic [US_W-1:0]   total;
  } acc_t;

  // total split into whole seconds and leftover microseconds
  typedef struct packed {
    acc_t             acc;
    logic [SEC_W-1:0] q;
    logic [REM_W-1:0] r;
  } quo_t;

endpackage

`default_nettype wire

// ----- design/calibrated_elapsed_sleep_timer.sv -----
// Top level of the calibrated elapsed-time and sleep timer.
// Tick scaling, microsecond accumulator, sleep bookkeeping; uses cest_pkg, cest_div.
//
//   channel   | signals                                  | payload
//   ----------+------------------------------------------+------------------
//   request   | item_valid / item_ready / item           | cest_pkg::item_t
//   result    | result_valid / result_ready / result     | cest_pkg::result_t
//
// One request per cycle is taken while item_ready is high; each gives exactly one result.
// The path is input register, delta, two 32x32 products, scale, accumulate,
// eight divider stages (four quotient chunks of 18 bits) and the result register.
// Reset clears all valid bits and the timer state; a stalled result holds only its
// own register while the stages behind it keep filling, and new requests are
// refused only once all fourteen stages hold requests.
`default_nettype none

module calibrated_elapsed_sleep_timer #(
  parameter int CAL_FRACTION_BITS = 19,
  parameter int TICK_WIDTH        = 48
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  cest_pkg::item_t     item,
  output logic                result_valid,
  input  logic                result_ready,
  output cest_pkg::result_t   result
);

  localparam int W64 = cest_pkg::US_W;
  localparam int SW  = cest_pkg::SEC_W;
  localparam int RW  = cest_pkg::REM_W;
  localparam int CW  = cest_pkg::CAL_W;

  typedef struct packed {
    logic [cest_pkg::KIND_W-1:0] kind;
    logic                        woke;
    logic                        upd;
    logic                        restart;
    logic [CW-1:0]               cal;
    logic [TICK_WIDTH-1:0]       delta;
  } dlt_t;

  typedef struct packed {
    logic [cest_pkg::KIND_W-1:0] kind;
    logic                        woke;
    logic                        upd;
    logic                        restart;
    logic [W64-1:0]              plo;
    logic [W64-1:0]              phi;
  } prd_t;

  typedef struct packed {
    logic [cest_pkg::KIND_W-1:0] kind;
    logic                        woke;
    logic                        upd;
    logic                        restart;
    logic [W64-1:0]              scaled;
  } scl_t;

  // pipeline registers
  cest_pkg::item_t in_reg;
  logic            in_vld;
  dlt_t            dlt;
  logic            dlt_vld;
  prd_t            prd;
  logic            prd_vld;
  scl_t            scl;
  logic            scl_vld;
  cest_pkg::acc_t  acc;
  logic            acc_vld;

  logic ld_in, ld_dlt, ld_prd, ld_scl, ld_acc, ld_out;
  logic div_ready, div_vld;
  cest_pkg::quo_t quo;

  // counter state
  logic                  elapsed_valid;
  logic [CW-1:0]         interval_cal;
  logic [TICK_WIDTH-1:0] last_ticks;
  logic [W64-1:0]        total_us;

  // sleep state
  logic          sleep_valid;
  logic          sleep_armed;
  logic [W64-1:0] sleep_start_us;
  logic [SW-1:0] start_sec;
  logic [RW-1:0] start_rem;
  logic [SW-1:0] last_sleep_seconds;

  // stage loads, back to front
  assign ld_out     = !result_valid || result_ready;
  assign ld_acc     = !acc_vld || div_ready;
  assign ld_scl     = !scl_vld || ld_acc;
  assign ld_prd     = !prd_vld || ld_scl;
  assign ld_dlt     = !dlt_vld || ld_prd;
  assign ld_in      = !in_vld || ld_dlt;
  assign item_ready = ld_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld       <= 1'b0;
      dlt_vld      <= 1'b0;
      prd_vld      <= 1'b0;
      scl_vld      <= 1'b0;
      acc_vld      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (ld_in)  in_vld       <= item_valid;
      if (ld_dlt) dlt_vld      <= in_vld;
      if (ld_prd) prd_vld      <= dlt_vld;
      if (ld_scl) scl_vld      <= prd_vld;
      if (ld_acc) acc_vld      <= scl_vld;
      if (ld_out) result_valid <= div_vld;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (ld_in) begin
      in_reg <= item;
    end
  end

  // restart decision and tick delta against the previous sample
  logic [TICK_WIDTH-1:0] now_t;
  logic                  in_upd;
  dlt_t                  dlt_next;

  always_comb begin
    now_t  = TICK_WIDTH'(in_reg.tick_count);
    in_upd = (in_reg.kind == cest_pkg::KIND_SAMPLE) ||
             (in_reg.kind == cest_pkg::KIND_SHUTDOWN) ||
             (in_reg.kind == cest_pkg::KIND_BOOT);
    dlt_next.kind    = in_reg.kind;
    dlt_next.woke    = in_reg.woke_from_sleep;
    dlt_next.upd     = in_upd;
    dlt_next.restart = !elapsed_valid || (interval_cal == '0) ||
                       (in_reg.period_cal == '0) || (last_ticks > now_t);
    dlt_next.cal     = interval_cal;
    dlt_next.delta   = now_t - last_ticks;
  end

  always_ff @(posedge clk) begin
    if (ld_dlt) begin
      dlt <= dlt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_valid <= 1'b0;
      interval_cal  <= '0;
      last_ticks    <= '0;
    end else if (ld_dlt && in_vld && in_upd) begin
      elapsed_valid <= 1'b1;
      interval_cal  <= in_reg.period_cal;
      last_ticks    <= now_t;
    end
  end

  // split products of the delta halves by the interval calibration
  logic [W64-1:0] delta_ext;
  prd_t           prd_next;

  always_comb begin
    delta_ext        = W64'(dlt.delta);
    prd_next.kind    = dlt.kind;
    prd_next.woke    = dlt.woke;
    prd_next.upd     = dlt.upd;
    prd_next.restart = dlt.restart;
    prd_next.plo     = W64'(delta_ext[31:0]) * W64'(dlt.cal);
    prd_next.phi     = W64'(delta_ext[63:32]) * W64'(dlt.cal);
  end

  always_ff @(posedge clk) begin
    if (ld_prd) begin
      prd <= prd_next;
    end
  end

  // fixed-point alignment of the two products
  scl_t scl_next;

  always_comb begin
    scl_next.kind    = prd.kind;
    scl_next.woke    = prd.woke;
    scl_next.upd     = prd.upd;
    scl_next.restart = prd.restart;
    scl_next.scaled  = (prd.plo >> CAL_FRACTION_BITS) +
                       (prd.phi << (32 - CAL_FRACTION_BITS));
  end

  always_ff @(posedge clk) begin
    if (ld_scl) begin
      scl <= scl_next;
    end
  end

  // microsecond accumulator
  logic [W64-1:0] total_next;
  cest_pkg::acc_t acc_next;

  always_comb begin
    total_next    = scl.restart ? '0 : total_us + scl.scaled;
    acc_next.kind = scl.kind;
    acc_next.woke = scl.woke;
    acc_next.total = scl.upd ? total_next : total_us;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_us <= '0;
    end else if (ld_acc && scl_vld && scl.upd) begin
      total_us <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_acc) begin
      acc <= acc_next;
    end
  end

  // seconds and leftover microseconds of the total
  cest_div u_div (
    .clk       (clk),
    .rst       (rst),
    .req_valid (acc_vld),
    .req_ready (div_ready),
    .req       (acc),
    .rsp_valid (div_vld),
    .rsp_ready (ld_out),
    .rsp       (quo)
  );

  // sleep bookkeeping; elapsed sleep comes from split seconds and remainders
  logic           sv_next;
  logic           armed_next;
  logic [W64-1:0] start_next;
  logic [SW-1:0]  start_sec_next;
  logic [RW-1:0]  start_rem_next;
  logic [SW-1:0]  lss_next;

  always_comb begin
    sv_next        = sleep_valid;
    armed_next     = sleep_armed;
    start_next     = sleep_start_us;
    start_sec_next = start_sec;
    start_rem_next = start_rem;
    lss_next       = last_sleep_seconds;
    unique case (quo.acc.kind)
      cest_pkg::KIND_SHUTDOWN: begin
        sv_next        = 1'b1;
        armed_next     = 1'b1;
        start_next     = quo.acc.total;
        start_sec_next = quo.q;
        start_rem_next = quo.r;
      end
      cest_pkg::KIND_BOOT: begin
        armed_next = 1'b0;
        if (!sleep_valid || (sleep_start_us > quo.acc.total) ||
            (last_sleep_seconds > quo.q)) begin
          sv_next        = 1'b1;
          start_next     = quo.acc.total;
          start_sec_next = quo.q;
          start_rem_next = quo.r;
          lss_next       = '0;
        end else if (quo.acc.woke && sleep_armed) begin
          lss_next = quo.q - start_sec - SW'(quo.r < start_rem);
        end
      end
      cest_pkg::KIND_CLEAR: begin
        sv_next  = 1'b1;
        lss_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sleep_valid        <= 1'b0;
      sleep_armed        <= 1'b0;
      sleep_start_us     <= '0;
      start_sec          <= '0;
      start_rem          <= '0;
      last_sleep_seconds <= '0;
    end else if (ld_out && div_vld) begin
      sleep_valid        <= sv_next;
      sleep_armed        <= armed_next;
      sleep_start_us     <= start_next;
      start_sec          <= start_sec_next;
      start_rem          <= start_rem_next;
      last_sleep_seconds <= lss_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ld_out) begin
      result.elapsed_us         <= quo.acc.total;
      result.elapsed_seconds    <= quo.q;
      result.inactivity_seconds <= sv_next ? lss_next : '0;
    end
  end

endmodule

`default_nettype wire

// ----- design/cest_div.sv -----
// Pipelined divide of the 64-bit microsecond total by one million.
// Four 18-bit quotient chunks, two stages each (reciprocal multiply, remainder).
// Depends on cest_pkg.
`default_nettype none

module cest_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  cest_pkg::acc_t    req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output cest_pkg::quo_t    rsp
);

  // total / 1e6 == (total >> 6) / 15625
  localparam int STEPS       = 4;
  localparam int STAGES      = 2 * STEPS;
  localparam int CHUNK_W     = 18;
  localparam int CORE_W      = 14;
  localparam int PRE_SHIFT   = 6;
  localparam int XP_W        = STEPS * CHUNK_W;
  localparam int N_W         = CORE_W + CHUNK_W;
  localparam int RECIP_W     = 33;
  localparam int PROD_W      = N_W + RECIP_W;
  localparam int RECIP_SHIFT = 46;
  localparam logic [CORE_W-1:0]  DIV_CORE  = 14'd15625;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 33'd4503599628;

  typedef struct packed {
    cest_pkg::acc_t             tag;
    logic [cest_pkg::SEC_W-1:0] q;
    logic [CORE_W-1:0]          rem;
    logic [N_W-1:0]             n;
    logic [CHUNK_W-1:0]         qc;
  } stage_t;

  stage_t [STAGES-1:0] stg;
  stage_t [STAGES-1:0] nxt;
  logic   [STAGES-1:0] vld;
  logic   [STAGES-1:0] load;

  // a stage loads when empty or when the stage after it moves
  always_comb begin
    load[STAGES-1] = !vld[STAGES-1] || rsp_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      load[k] = !vld[k] || load[k+1];
    end
  end

  assign req_ready = load[0];

  // even stages: reciprocal multiply on one chunk; odd stages: remainder
  always_comb begin
    stage_t              src;
    logic [XP_W-1:0]     xp;
    logic [PROD_W-1:0]   prod;
    logic [N_W-1:0]      sub;
    for (int k = 0; k < STAGES; k++) begin
      if (k == 0) begin
        src     = '0;
        src.tag = req;
      end else begin
        src = stg[k-1];
      end
      nxt[k] = src;
      xp     = XP_W'(src.tag.total[cest_pkg::US_W-1:PRE_SHIFT]);
      prod   = '0;
      sub    = '0;
      if ((k & 1) == 0) begin
        nxt[k].n  = {src.rem, xp[XP_W-1-CHUNK_W*(k>>1) -: CHUNK_W]};
        prod      = PROD_W'(nxt[k].n) * PROD_W'(DIV_RECIP);
        nxt[k].qc = prod[RECIP_SHIFT +: CHUNK_W];
      end else begin
        sub        = src.n - (N_W'(src.qc) * N_W'(DIV_CORE));
        nxt[k].rem = sub[CORE_W-1:0];
        nxt[k].q   = cest_pkg::SEC_W'({src.q, src.qc});
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (vld & ~load) | ({vld[STAGES-2:0], req_valid} & load);
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    for (int k = 0; k < STAGES; k++) begin
      if (load[k]) begin
        stg[k] <= nxt[k];
      end
    end
  end

  assign rsp_valid = vld[STAGES-1];
  assign rsp.acc   = stg[STAGES-1].tag;
  assign rsp.q     = stg[STAGES-1].q;
  assign rsp.r     = {stg[STAGES-1].rem, stg[STAGES-1].tag.total[PRE_SHIFT-1:0]};

endmodule

`default_nettype wire

// ----- design/cest_check.sv -----
// Port-level checks for the calibrated elapsed-time and sleep timer.
// Watches the request and result channels only; bound to the top level below.
// Depends on cest_pkg.
`default_nettype none

module cest_check (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input logic              result_valid,
  input logic              result_ready,
  input cest_pkg::result_t result
);

  localparam int          CAPACITY = 14;
  localparam int          CNT_W    = 5;
  localparam int          WIDE_W   = 85;
  localparam logic [WIDE_W-1:0] US_PER_SECOND = 85'd1000000;

  logic [CNT_W-1:0]  pending;
  logic              in_acc;
  logic              out_acc;
  logic [WIDE_W-1:0] sec_lo;
  logic [WIDE_W-1:0] sec_hi;
  logic [WIDE_W-1:0] us_wide;
  logic              sec_ok;

  assign in_acc  = item_valid && item_ready;
  assign out_acc = result_valid && result_ready;

  // requests taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  // seconds field brackets the microsecond field
  always_comb begin
    us_wide = WIDE_W'(result.elapsed_us);
    sec_lo  = WIDE_W'(result.elapsed_seconds) * US_PER_SECOND;
    sec_hi  = sec_lo + US_PER_SECOND;
    sec_ok  = (sec_lo <= us_wide) && (us_wide < sec_hi);
  end

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed or dropped while stalled");

  a_no_extra_result: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pending != '0)
    else $error("result shown with no request outstanding");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    pending <= CNT_W'(CAPACITY))
    else $error("more requests in flight than pipeline stages");

  a_seconds_match: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> sec_ok)
    else $error("elapsed_seconds does not match elapsed_us");

endmodule

bind calibrated_elapsed_sleep_timer cest_check u_cest_check (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

`default_nettype wire

// ----- verif/calibrated_elapsed_sleep_timer_test.sv -----
// Self-checking testbench for calibrated_elapsed_sleep_timer: tick scaling, elapsed total,
// sleep bookkeeping, all request kinds under random idling on both channels.
// Depends on cest_pkg and the block's RTL only.
`timescale 1ns / 1ps

module calibrated_elapsed_sleep_timer_test;

  localparam int FRAC_BITS = 19;
  localparam int KIND_LAST = (1 << cest_pkg::KIND_W) - 1;
  localparam logic [63:0] US_PER_S = 64'd1000000;
  localparam logic [cest_pkg::CAL_W-1:0] CAL_NOM = 32'h00F4_0000;
  localparam logic [cest_pkg::CAL_W-1:0] CAL_MAX = 32'hFFFF_FFFF;
  localparam logic [cest_pkg::TICKS_W-1:0] TICK_MAX = 48'hFFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  cest_pkg::item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  cest_pkg::result_t result;

  // predicted timer state
  logic have_base = 1'b0;
  logic [cest_pkg::CAL_W-1:0] span_cal = '0;
  logic [cest_pkg::TICKS_W-1:0] prev_ticks = '0;
  logic [63:0] acc_us = '0;
  logic sleep_ok = 1'b0;
  logic sleep_marker = 1'b0;
  logic [63:0] sleep_mark_us = '0;
  logic [63:0] slept_s = '0;

  cest_pkg::result_t pending_results[$];
  logic [cest_pkg::TICKS_W-1:0] session_ticks = 48'd5000;
  bit calm = 1'b0;
  int errors = 0;
  int checked = 0;
  int kind_seen[8];

  calibrated_elapsed_sleep_timer uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("calibrated_elapsed_sleep_timer: mismatch");
    $finish;
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 22);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  // advance the microsecond total, restarting on invalid state, zero cal or backward ticks
  function automatic logic [63:0] step_counter(logic [cest_pkg::TICKS_W-1:0] ticks,
                                               logic [cest_pkg::CAL_W-1:0] cal);
    logic [63:0] span;
    logic [63:0] lo_part;
    logic [63:0] hi_part;
    if (!have_base || span_cal == '0 || cal == '0 || prev_ticks > ticks) begin
      have_base = 1'b1;
      span_cal = cal;
      prev_ticks = ticks;
      acc_us = '0;
    end else begin
      span = 64'(ticks - prev_ticks);
      lo_part = (64'(span[31:0]) * 64'(span_cal)) >> FRAC_BITS;
      hi_part = (64'(span[63:32]) * 64'(span_cal)) << (32 - FRAC_BITS);
      acc_us = acc_us + lo_part + hi_part;
      prev_ticks = ticks;
      span_cal = cal;
    end
    return acc_us;
  endfunction

  function automatic cest_pkg::result_t predict_timer_result(cest_pkg::item_t req);
    logic [63:0] now_us;
    cest_pkg::result_t res;
    case (req.kind)
      cest_pkg::KIND_SAMPLE: begin
        now_us = step_counter(req.tick_count, req.period_cal);
      end
      cest_pkg::KIND_SHUTDOWN: begin
        now_us = step_counter(req.tick_count, req.period_cal);
        sleep_ok = 1'b1;
        sleep_mark_us = now_us;
        sleep_marker = 1'b1;
      end
      cest_pkg::KIND_BOOT: begin
        now_us = step_counter(req.tick_count, req.period_cal);
        if (!sleep_ok || sleep_mark_us > now_us || slept_s > now_us / US_PER_S) begin
          sleep_ok = 1'b1;
          sleep_marker = 1'b0;
          sleep_mark_us = now_us;
          slept_s = '0;
        end else begin
          if (req.woke_from_sleep && sleep_marker) begin
            slept_s = (now_us - sleep_mark_us) / US_PER_S;
          end
          sleep_marker = 1'b0;
        end
      end
      cest_pkg::KIND_CLEAR: begin
        slept_s = '0;
        sleep_ok = 1'b1;
      end
      default: begin
      end
    endcase
    res.elapsed_us = acc_us;
    res.elapsed_seconds = cest_pkg::SEC_W'(acc_us / US_PER_S);
    res.inactivity_seconds = sleep_ok ? slept_s[cest_pkg::SEC_W-1:0] : '0;
    return res;
  endfunction

  function automatic cest_pkg::item_t make_request(logic [cest_pkg::KIND_W-1:0] kind,
                                                   logic [cest_pkg::TICKS_W-1:0] ticks,
                                                   logic [cest_pkg::CAL_W-1:0] cal,
                                                   logic woke);
    cest_pkg::item_t req;
    req.kind = kind;
    req.tick_count = ticks;
    req.period_cal = cal;
    req.woke_from_sleep = woke;
    return req;
  endfunction

  function automatic logic [cest_pkg::TICKS_W-1:0] rand_ticks();
    return cest_pkg::TICKS_W'({$urandom, $urandom});
  endfunction

  // any kind code, used ones and unused ones alike
  function automatic logic [cest_pkg::KIND_W-1:0] rand_kind();
    return cest_pkg::KIND_W'($urandom);
  endfunction

  // mostly a realistic ~30 us tick period, sometimes any value
  function automatic logic [cest_pkg::CAL_W-1:0] nominal_cal();
    if ($urandom_range(9) == 0) begin
      return $urandom;
    end
    return 32'h00E0_0000 + $urandom_range(0, 32'h003F_FFFF);
  endfunction

  // record each accepted request and check each accepted result
  always @(posedge clk) begin : watch_handshakes
    cest_pkg::result_t want;
    if (!rst) begin
      if (item_valid && item_ready) begin
        pending_results.push_back(predict_timer_result(item));
        kind_seen[item.kind]++;
      end
      if (result_valid && result_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing pending, got %h", $time, result);
          errors++;
        end else begin
          want = pending_results.pop_front();
          checked++;
          if (want.elapsed_us !== result.elapsed_us) begin
            $display("%0t: elapsed_us expected %h got %h", $time,
                     want.elapsed_us, result.elapsed_us);
            errors++;
          end
          if (want.elapsed_seconds !== result.elapsed_seconds) begin
            $display("%0t: elapsed_seconds expected %h got %h", $time,
                     want.elapsed_seconds, result.elapsed_seconds);
            errors++;
          end
          if (want.inactivity_seconds !== result.inactivity_seconds) begin
            $display("%0t: inactivity_seconds expected %h got %h", $time,
                     want.inactivity_seconds, result.inactivity_seconds);
            errors++;
          end
        end
      end
    end
  end

  // result side stalls at random
  always @(negedge clk) begin
    result_ready <= !take_break();
  end

  // send one request; starts and ends at a falling edge
  task automatic send_request(input cest_pkg::item_t req);
    while (take_break()) begin
      @(negedge clk);
    end
    item = req;
    item_valid = 1'b1;
    @(posedge clk);
    while (!item_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    item_valid = 1'b0;
  endtask

  task automatic drain_pending();
    item_valid = 1'b0;
    while (pending_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic test_directed_cases();
    // query straight out of reset
    send_request(make_request(cest_pkg::KIND_QUERY, 48'd0, 32'd0, 1'b0));
    // zero cal restarts, then a zero interval cal restarts again
    send_request(make_request(cest_pkg::KIND_SAMPLE, 48'd1000, 32'd0, 1'b0));
    send_request(make_request(cest_pkg::KIND_SAMPLE, 48'd2000, CAL_NOM, 1'b0));
    send_request(make_request(cest_pkg::KIND_SAMPLE, 48'd42000, CAL_NOM, 1'b1));
    // boot with sleep state never set
    send_request(make_request(cest_pkg::KIND_BOOT, 48'd50000, CAL_NOM, 1'b0));
    // shutdown, then a wake boot far ahead so the high tick word is used
    send_request(make_request(cest_pkg::KIND_SHUTDOWN, 48'd1050000, CAL_MAX, 1'b0));
    send_request(make_request(cest_pkg::KIND_BOOT, 48'd1050000 + (48'd1 << 40), CAL_NOM,
                              1'b1));
    // second boot: marker already cleared
    send_request(make_request(cest_pkg::KIND_BOOT, 48'd1050000 + (48'd1 << 40), CAL_NOM,
                              1'b1));
    // unused kinds and an inactivity clear, with junk fields
    for (int k = int'(cest_pkg::KIND_QUERY) + 1; k <= KIND_LAST; k++) begin
      send_request(make_request(cest_pkg::KIND_W'(k), TICK_MAX, CAL_MAX, 1'b1));
    end
    send_request(make_request(cest_pkg::KIND_CLEAR, TICK_MAX, CAL_MAX, 1'b1));
    // shutdown at the top of the tick range, then ticks go backwards
    send_request(make_request(cest_pkg::KIND_SHUTDOWN, TICK_MAX, CAL_NOM, 1'b0));
    send_request(make_request(cest_pkg::KIND_SAMPLE, 48'd0, CAL_MAX, 1'b0));
    // sleep start now lies past the total
    send_request(make_request(cest_pkg::KIND_BOOT, 48'd10, CAL_MAX, 1'b1));
    // whole tick range at max cal
    send_request(make_request(cest_pkg::KIND_SAMPLE, TICK_MAX, CAL_MAX, 1'b0));
    send_request(make_request(cest_pkg::KIND_QUERY, 48'd0, 32'd0, 1'b0));
    // long sleep recorded, then counter restart so it exceeds the new total
    send_request(make_request(cest_pkg::KIND_SAMPLE, 48'd0, CAL_NOM, 1'b0));
    send_request(make_request(cest_pkg::KIND_SHUTDOWN, 48'd0, CAL_NOM, 1'b0));
    send_request(make_request(cest_pkg::KIND_BOOT, 48'd1 << 36, CAL_NOM, 1'b1));
    send_request(make_request(cest_pkg::KIND_SAMPLE, 48'd0, CAL_NOM, 1'b0));
    send_request(make_request(cest_pkg::KIND_SAMPLE, 48'd100, CAL_NOM, 1'b0));
    send_request(make_request(cest_pkg::KIND_BOOT, 48'd200, CAL_NOM, 1'b1));
    // zero current cal while valid
    send_request(make_request(cest_pkg::KIND_SAMPLE, 48'd300, 32'd0, 1'b0));
    drain_pending();
  endtask

  // mostly well-formed sample / shutdown / wake sequences, some noise
  task automatic test_sleep_sessions(input int count);
    int sent;
    int pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        session_ticks = session_ticks + cest_pkg::TICKS_W'($urandom_range(1, 200000));
        send_request(make_request(cest_pkg::KIND_SAMPLE, session_ticks, nominal_cal(),
                                  rand_bit()));
        sent += 1;
      end else if (pick < 57) begin
        send_request(make_request(cest_pkg::KIND_SHUTDOWN, session_ticks, nominal_cal(),
                                  rand_bit()));
        session_ticks = session_ticks + cest_pkg::TICKS_W'($urandom_range(0, 1 << 24));
        send_request(make_request(cest_pkg::KIND_BOOT, session_ticks, nominal_cal(),
                                  $urandom_range(9) != 0));
        sent += 2;
      end else if (pick < 65) begin
        session_ticks = session_ticks + cest_pkg::TICKS_W'($urandom_range(0, 100000));
        send_request(make_request(cest_pkg::KIND_BOOT, session_ticks, nominal_cal(),
                                  rand_bit()));
        sent += 1;
      end else if (pick < 73) begin
        send_request(make_request(
            cest_pkg::KIND_W'($urandom_range(int'(cest_pkg::KIND_QUERY), KIND_LAST)),
            rand_ticks(), $urandom, rand_bit()));
        sent += 1;
      end else if (pick < 78) begin
        send_request(make_request(cest_pkg::KIND_CLEAR, rand_ticks(), $urandom, rand_bit()));
        sent += 1;
      end else if (pick < 80) begin
        drain_pending();
      end else if (pick < 85) begin
        // jump to a new tick base
        session_ticks = rand_ticks() >> 1;
        send_request(make_request(cest_pkg::KIND_SAMPLE, session_ticks, nominal_cal(),
                                  rand_bit()));
        sent += 1;
      end else if (pick < 91) begin
        session_ticks = session_ticks - cest_pkg::TICKS_W'($urandom_range(1, 100000));
        send_request(make_request(cest_pkg::KIND_SAMPLE, session_ticks, nominal_cal(),
                                  rand_bit()));
        sent += 1;
      end else if (pick < 95) begin
        session_ticks = session_ticks + cest_pkg::TICKS_W'($urandom_range(0, 1000));
        send_request(make_request(
            cest_pkg::KIND_W'($urandom_range(int'(cest_pkg::KIND_BOOT))),
            session_ticks, 32'd0, rand_bit()));
        sent += 1;
      end else begin
        send_request(make_request(rand_kind(), rand_ticks(), $urandom, rand_bit()));
        sent += 1;
      end
    end
    drain_pending();
  endtask

  // no idling on either side
  task automatic test_steady_stream();
    calm = 1'b1;
    test_sleep_sessions(150);
    calm = 1'b0;
  endtask

  task automatic test_random_fields();
    repeat (120) begin
      send_request(make_request(rand_kind(), rand_ticks(), $urandom, rand_bit()));
    end
    drain_pending();
  endtask

  // sender waits for every pending result before going on
  task automatic test_drain_pauses();
    repeat (8) begin
      test_sleep_sessions(4);
      drain_pending();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_cases();
    test_sleep_sessions(500);
    test_steady_stream();
    test_random_fields();
    test_drain_pauses();
    drain_pending();
    repeat (30) @(negedge clk);
    $display("covered %0d samples, %0d shutdowns, %0d boots, %0d clears, %0d queries/unused",
             kind_seen[cest_pkg::KIND_SAMPLE], kind_seen[cest_pkg::KIND_SHUTDOWN],
             kind_seen[cest_pkg::KIND_BOOT], kind_seen[cest_pkg::KIND_CLEAR],
             kind_seen.sum() - kind_seen[cest_pkg::KIND_SAMPLE] -
             kind_seen[cest_pkg::KIND_SHUTDOWN] - kind_seen[cest_pkg::KIND_BOOT] -
             kind_seen[cest_pkg::KIND_CLEAR]);
    $display("%0d results compared, %0d mismatches", checked, errors);
    if (errors == 0) begin
      $display("calibrated_elapsed_sleep_timer: match");
    end else begin
      $display("calibrated_elapsed_sleep_timer: mismatch");
    end
    $finish;
  end

endmodule
